// File: design/kf800_pkg.sv
// Keccak-f[800] engine package: types, command codes, round constants and round function.
package kf800_pkg;

    localparam int LANES        = 25;
    localparam int LANE_W       = 32;
    localparam int LANE_IDX_W   = 5;
    localparam int TOTAL_ROUNDS = 22;
    localparam int ROUND_W      = 5;
    localparam int CMD_W        = 3;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 8;

    typedef logic [LANE_W-1:0] lane_t;
    typedef logic [LANES-1:0][LANE_W-1:0] state_t;
    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_XOR         = 3'd0;
    localparam cmd_t CMD_OVERWRITE   = 3'd1;
    localparam cmd_t CMD_EXTRACT     = 3'd2;
    localparam cmd_t CMD_EXTRACT_XOR = 3'd3;
    localparam cmd_t CMD_PERMUTE     = 3'd4;
    localparam cmd_t CMD_CLEAR       = 3'd5;
    localparam cmd_t CMD_ABSORB_END  = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_RATE_LANES    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRAILING_BITS = 1'd1;

    function automatic lane_t round_const(input logic [ROUND_W-1:0] idx);
        lane_t rc;
        case (idx)
            5'd0:    rc = 32'h00000001;
            5'd1:    rc = 32'h00008082;
            5'd2:    rc = 32'h0000808a;
            5'd3:    rc = 32'h80008000;
            5'd4:    rc = 32'h0000808b;
            5'd5:    rc = 32'h80000001;
            5'd6:    rc = 32'h80008081;
            5'd7:    rc = 32'h00008009;
            5'd8:    rc = 32'h0000008a;
            5'd9:    rc = 32'h00000088;
            5'd10:   rc = 32'h80008009;
            5'd11:   rc = 32'h8000000a;
            5'd12:   rc = 32'h8000808b;
            5'd13:   rc = 32'h0000008b;
            5'd14:   rc = 32'h00008089;
            5'd15:   rc = 32'h00008003;
            5'd16:   rc = 32'h00008002;
            5'd17:   rc = 32'h00000080;
            5'd18:   rc = 32'h0000800a;
            5'd19:   rc = 32'h8000000a;
            5'd20:   rc = 32'h80008081;
            5'd21:   rc = 32'h00008080;
            default: rc = '0;
        endcase
        return rc;
    endfunction

    localparam int RHO_OFF [LANES] = '{
        0, 1, 30, 28, 27,
        4, 12, 6, 23, 20,
        3, 10, 11, 25, 7,
        9, 13, 15, 21, 8,
        18, 2, 29, 24, 14
    };

    function automatic lane_t rotl(input lane_t v, input int n);
        lane_t r;
        if (n == 0)
        begin
            r = v;
        end
        else
        begin
            r = (v << n) | (v >> (LANE_W - n));
        end
        return r;
    endfunction

    // theta, rho, pi, chi, iota
    function automatic state_t keccak_round(input state_t s, input lane_t rc);
        lane_t  c [5];
        lane_t  d [5];
        state_t a;
        state_t b;
        state_t r;
        a = s;
        for (int x = 0; x < 5; x++)
        begin
            c[x] = s[x] ^ s[x+5] ^ s[x+10] ^ s[x+15] ^ s[x+20];
        end
        for (int x = 0; x < 5; x++)
        begin
            d[x] = c[(x+4)%5] ^ rotl(c[(x+1)%5], 1);
        end
        for (int x = 0; x < 5; x++)
        begin
            for (int y = 0; y < 5; y++)
            begin
                a[x+5*y] = s[x+5*y] ^ d[x];
            end
        end
        for (int x = 0; x < 5; x++)
        begin
            for (int y = 0; y < 5; y++)
            begin
                b[y+5*((2*x+3*y)%5)] = rotl(a[x+5*y], RHO_OFF[x+5*y]);
            end
        end
        for (int y = 0; y < 5; y++)
        begin
            for (int x = 0; x < 5; x++)
            begin
                r[x+5*y] = b[x+5*y] ^ (~b[(x+1)%5+5*y] & b[(x+2)%5+5*y]);
            end
        end
        r[0] = r[0] ^ rc;
        return r;
    endfunction

endpackage

// File: design/keccak_f800_state_engine_top.sv
// Keccak-f[800] state engine: lane command port, round sequencer and extract output queue.
//
//  channel | handshake            | fields
//  --------+----------------------+---------------------------------------------
//  input   | in_valid / in_stall  | cmd, lane_index, data_word, byte_mask
//  output  | out_valid / out_stall| lane_data, lane_number
//  config  | cfg_write            | cfg_index, cfg_data
//
// Lane commands and clear update the state register directly. Permute and absorb_end run
// NUM_ROUNDS rounds, one full round per cycle through the single round unit; in_stall is high
// while rounds run. Extract words go to an output register backed by one skid entry;
// in_stall also rises while the skid entry is full. Reset clears the state to zero.
module keccak_f800_state_engine_top
    import kf800_pkg::*;
#(
    parameter int NUM_ROUNDS = 22
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [CMD_W-1:0]      cmd,
    input  logic [LANE_IDX_W-1:0] lane_index,
    input  logic [LANE_W-1:0]     data_word,
    input  logic [3:0]            byte_mask,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [LANE_W-1:0]     lane_data,
    output logic [LANE_IDX_W-1:0] lane_number,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int FIRST_ROUND = TOTAL_ROUNDS - NUM_ROUNDS;
    localparam logic [ROUND_W-1:0] LAST_CNT  = ROUND_W'(NUM_ROUNDS - 1);
    localparam logic [ROUND_W-1:0] FIRST_IDX = ROUND_W'(FIRST_ROUND);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_ROUND = 1'b1;

    logic                  fsm_reg, fsm_next;
    logic [ROUND_W-1:0]    round_cnt_reg, round_cnt_next;
    state_t                state_reg, state_next;
    logic [LANE_IDX_W-1:0] rate_lanes_reg;
    logic [7:0]            trailing_bits_reg;

    logic                  out_valid_reg, out_valid_next;
    lane_t                 out_data_reg, out_data_next;
    logic [LANE_IDX_W-1:0] out_lane_reg, out_lane_next;
    logic                  skid_valid_reg, skid_valid_next;
    lane_t                 skid_data_reg, skid_data_next;
    logic [LANE_IDX_W-1:0] skid_lane_reg, skid_lane_next;

    logic                  in_take;
    logic                  out_take;
    logic                  lane_ok;
    lane_t                 mask;
    lane_t                 cur;
    logic                  res_new;
    lane_t                 res_data;

    assign in_stall    = (fsm_reg == ST_ROUND) || skid_valid_reg;
    assign in_take     = in_valid && !in_stall;
    assign out_take    = out_valid_reg && !out_stall;
    assign out_valid   = out_valid_reg;
    assign lane_data   = out_data_reg;
    assign lane_number = out_lane_reg;

    assign lane_ok = lane_index < LANE_IDX_W'(LANES);
    assign mask    = {{8{byte_mask[3]}}, {8{byte_mask[2]}}, {8{byte_mask[1]}},
                      {8{byte_mask[0]}}};
    assign cur     = lane_ok ? state_reg[lane_index] : '0;

    always_comb
    begin
        fsm_next       = fsm_reg;
        round_cnt_next = round_cnt_reg;
        state_next     = state_reg;
        res_new        = 1'b0;
        res_data       = '0;
        if (fsm_reg == ST_ROUND)
        begin
            state_next = keccak_round(state_reg, round_const(round_cnt_reg + FIRST_IDX));
            if (round_cnt_reg == LAST_CNT)
            begin
                fsm_next       = ST_IDLE;
                round_cnt_next = '0;
            end
            else
            begin
                round_cnt_next = round_cnt_reg + 1'b1;
            end
        end
        else if (in_take)
        begin
            case (cmd)
                CMD_XOR:
                begin
                    if (lane_ok)
                    begin
                        state_next[lane_index] = cur ^ (data_word & mask);
                    end
                end
                CMD_OVERWRITE:
                begin
                    if (lane_ok)
                    begin
                        state_next[lane_index] = (cur & ~mask) | (data_word & mask);
                    end
                end
                CMD_EXTRACT:
                begin
                    res_new  = 1'b1;
                    res_data = cur & mask;
                end
                CMD_EXTRACT_XOR:
                begin
                    res_new  = 1'b1;
                    res_data = lane_ok ? ((cur ^ data_word) & mask) : '0;
                end
                CMD_PERMUTE:
                begin
                    fsm_next = ST_ROUND;
                end
                CMD_CLEAR:
                begin
                    state_next = '0;
                end
                CMD_ABSORB_END:
                begin
                    if (rate_lanes_reg < LANE_IDX_W'(LANES))
                    begin
                        state_next[rate_lanes_reg] =
                            state_reg[rate_lanes_reg] ^ {24'd0, trailing_bits_reg};
                    end
                    fsm_next = ST_ROUND;
                end
                default:
                begin
                end
            endcase
        end
    end

    // output register with one skid entry behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_lane_next   = out_lane_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_lane_next  = skid_lane_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_next   = skid_data_reg;
                out_lane_next   = skid_lane_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res_new)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res_data;
                out_lane_next  = lane_index;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res_data;
                skid_lane_next  = lane_index;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg           <= ST_IDLE;
            round_cnt_reg     <= '0;
            state_reg         <= '0;
            rate_lanes_reg    <= 5'd16;
            trailing_bits_reg <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            fsm_reg        <= fsm_next;
            round_cnt_reg  <= round_cnt_next;
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_RATE_LANES:    rate_lanes_reg    <= cfg_data[LANE_IDX_W-1:0];
                    REG_TRAILING_BITS: trailing_bits_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_lane_reg  <= out_lane_next;
        skid_data_reg <= skid_data_next;
        skid_lane_reg <= skid_lane_next;
    end

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == ST_ROUND) |-> in_stall)
        else $error("input taken during rounds");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full with output register empty");

    a_cnt_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (fsm_reg == ST_IDLE) |-> (round_cnt_reg == '0))
        else $error("round counter nonzero while idle");

    a_permute_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && (cmd == CMD_PERMUTE || cmd == CMD_ABSORB_END)) |=> (fsm_reg == ST_ROUND))
        else $error("permute did not start rounds");

endmodule
